@@ rtl/lzss_pkg.sv @@
package lzss_pkg;

  // History window
  localparam int WinSize = 4096;
  localparam int WinAw   = $clog2(WinSize);

  // Token format
  localparam int LenW          = 5;
  localparam int MinMatch      = 3;
  localparam int TokensPerFlag = 8;
  localparam int TokCntW       = 4;

  // Output byte count
  localparam int CntW = 24;

  // Command queue between parser and copy engine
  localparam int CmdQDepth = 2;
  localparam int CmdQAw    = $clog2(CmdQDepth);

  typedef enum logic [1:0] {
    PhFlag   = 2'd0,
    PhToken  = 2'd1,
    PhMatch2 = 2'd2
  } phase_e;

  // One decoded token: a literal byte or a back reference
  typedef struct packed {
    logic             is_match;
    logic [7:0]       lit;
    logic [WinAw-1:0] offset;
    logic [LenW-1:0]  len;
  } cmd_t;

endpackage

@@ rtl/lzss_front.sv @@
module lzss_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [lzss_pkg::CntW-1:0] total_length_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             in_byte_i,
  input  logic                   cmd_full_i,
  output logic                   cmd_push_o,
  output lzss_pkg::cmd_t         cmd_o
);
  import lzss_pkg::*;

  phase_e               phase_q, phase_d;
  logic [7:0]           flag_q;
  logic [TokCntW-1:0]   tokens_q;
  logic [7:0]           low_q;
  logic [CntW-1:0]      prod_q, prod_d;
  logic [CntW-1:0]      room;
  logic [LenW-1:0]      match_len;
  logic                 ended;
  logic                 accept;
  logic                 work;

  assign ended     = (prod_q >= total_length_i);
  assign in_stall_o = cmd_full_i && !ended && (phase_q == PhToken || phase_q == PhMatch2);
  assign accept    = in_valid_i && !in_stall_o;
  assign work      = accept && !ended;
  assign match_len = {1'b0, in_byte_i[7:4]} + LenW'(MinMatch);
  assign room      = total_length_i - prod_q;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (work) begin
      unique case (phase_q)
        PhToken: begin
          if (flag_q[0]) begin
            phase_d = PhMatch2;
          end else begin
            phase_d = (tokens_q == TokCntW'(1)) ? PhFlag : PhToken;
          end
        end
        PhMatch2: begin
          phase_d = (tokens_q == TokCntW'(1)) ? PhFlag : PhToken;
        end
        default: begin
          phase_d = PhToken;
        end
      endcase
    end
  end

  // Command push and projected output count
  always_comb begin
    cmd_push_o      = 1'b0;
    cmd_o.is_match  = (phase_q == PhMatch2);
    cmd_o.lit       = in_byte_i;
    cmd_o.offset    = {in_byte_i[3:0], low_q};
    cmd_o.len       = match_len;
    prod_d          = prod_q;
    if (work) begin
      unique case (phase_q)
        PhToken: begin
          if (!flag_q[0]) begin
            cmd_push_o = 1'b1;
            prod_d     = prod_q + CntW'(1);
          end
        end
        PhMatch2: begin
          cmd_push_o = 1'b1;
          if (CntW'(match_len) >= room) begin
            prod_d = total_length_i;
          end else begin
            prod_d = prod_q + CntW'(match_len);
          end
        end
        default: begin
          cmd_push_o = 1'b0;
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhFlag;
      flag_q   <= '0;
      tokens_q <= '0;
      low_q    <= '0;
      prod_q   <= '0;
    end else begin
      phase_q <= phase_d;
      prod_q  <= prod_d;
      if (work) begin
        unique case (phase_q)
          PhToken: begin
            if (flag_q[0]) begin
              low_q <= in_byte_i;
            end else begin
              flag_q   <= {1'b0, flag_q[7:1]};
              tokens_q <= tokens_q - TokCntW'(1);
            end
          end
          PhMatch2: begin
            flag_q   <= {1'b0, flag_q[7:1]};
            tokens_q <= tokens_q - TokCntW'(1);
          end
          default: begin
            flag_q   <= in_byte_i;
            tokens_q <= TokCntW'(TokensPerFlag);
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/lzss_cmdq.sv @@
module lzss_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lzss_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lzss_pkg::cmd_t cmd_o
);
  import lzss_pkg::*;

  cmd_t              slot_q [CmdQDepth];
  logic [CmdQAw-1:0] wr_q, rd_q;
  logic [CmdQAw:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (CmdQAw+1)'(CmdQDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store incoming command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + CmdQAw'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + CmdQAw'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (CmdQAw+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (CmdQAw+1)'(1);
      end
    end
  end

endmodule

@@ rtl/lzss_back.sv @@
module lzss_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lzss_pkg::CntW-1:0] total_length_i,
  input  logic                      cmd_valid_i,
  input  lzss_pkg::cmd_t            cmd_i,
  output logic                      cmd_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                out_byte_o,
  output logic                      run_last_o,
  output logic                      done_res_o
);
  import lzss_pkg::*;

  // History memory and read data
  logic [7:0]       mem [WinSize];
  logic [7:0]       rd_q;

  // Job being copied
  logic             job_v_q;
  logic             job_match_q;
  logic [7:0]       job_lit_q;
  logic [WinAw-1:0] job_src_q;
  logic [LenW-1:0]  job_rem_q;

  // Positions and counts
  logic [WinAw-1:0] ipos_q, ipos_d;
  logic [WinAw-1:0] wr_ptr_q;
  logic             wrapped_q;
  logic [CntW-1:0]  prod_q, prod_inc;

  // Read stage
  logic             s1_v_q, s1_fwd_q, s1_zero_q, s1_last_q, s1_done_q;
  logic [7:0]       s1_fdata_q;
  logic [7:0]       s1_data;

  // Output register
  logic             out_v_q, out_last_q, out_done_q;
  logic [7:0]       out_byte_q;

  logic out_free, s1_move, issue, done_now, job_end, src_written, fwd_hit;

  // Handshake and hazard logic
  always_comb begin
    out_free    = !out_v_q || !out_stall_i;
    s1_move     = s1_v_q && out_free;
    issue       = job_v_q && (!s1_v_q || s1_move);
    prod_inc    = prod_q + CntW'(1);
    done_now    = (prod_inc == total_length_i);
    job_end     = (job_rem_q == LenW'(1)) || done_now;
    cmd_pop_o   = cmd_valid_i && (!job_v_q || (issue && job_end));
    ipos_d      = issue ? ipos_q + WinAw'(1) : ipos_q;
    src_written = wrapped_q || (job_src_q < wr_ptr_q);
    fwd_hit     = s1_move && (job_src_q == wr_ptr_q);
    s1_data     = s1_fwd_q ? s1_fdata_q : (s1_zero_q ? 8'd0 : rd_q);
  end

  // Write the history as bytes leave, read the next source byte
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      mem[wr_ptr_q] <= s1_data;
    end
    if (issue && job_match_q) begin
      rd_q <= mem[job_src_q];
    end
  end

  // Job payload
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      job_match_q <= cmd_i.is_match;
      job_lit_q   <= cmd_i.lit;
      job_src_q   <= ipos_d - cmd_i.offset;
      job_rem_q   <= cmd_i.is_match ? cmd_i.len : LenW'(1);
    end else if (issue) begin
      job_src_q <= job_src_q + WinAw'(1);
      job_rem_q <= job_rem_q - LenW'(1);
    end
    if (issue) begin
      s1_fwd_q   <= !job_match_q || fwd_hit;
      s1_fdata_q <= job_match_q ? s1_data : job_lit_q;
      s1_zero_q  <= !src_written;
      s1_last_q  <= job_end;
      s1_done_q  <= done_now;
    end
    if (s1_move) begin
      out_byte_q <= s1_data;
      out_last_q <= s1_last_q;
      out_done_q <= s1_done_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q   <= 1'b0;
      ipos_q    <= '0;
      wr_ptr_q  <= '0;
      wrapped_q <= 1'b0;
      prod_q    <= '0;
      s1_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        job_v_q <= 1'b1;
      end else if (issue && job_end) begin
        job_v_q <= 1'b0;
      end
      ipos_q <= ipos_d;
      if (issue) begin
        prod_q <= prod_inc;
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        wr_ptr_q <= wr_ptr_q + WinAw'(1);
        if (wr_ptr_q == '1) begin
          wrapped_q <= 1'b1;
        end
      end
      if (out_free) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;
  assign done_res_o  = out_done_q;

endmodule

@@ rtl/lzss_decompressor.sv @@
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  in_byte_i
// output    out        out_valid_o/out_stall_i out_byte_o, run_last_o, done_res_o
// config    in         cfg_we_i               cfg_wdata_i (total_length)
//
// A flag byte or the first byte of a match is taken and yields nothing.
// The copy engine's output pace is set by the single read port of the
// 4096-byte history; an idle engine first loads a command into its job register,
// and the first byte of an item passes the command queue, the job register, the
// read stage and the output register. Worst case a two-byte match gives 18 bytes.
// Reset clears the history by a fill mark: entries not yet written read as zero.
// Input stalls only when the two-entry command queue is full and a token is due.
module lzss_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        done_res_o
);
  import lzss_pkg::*;

  logic [CntW-1:0] total_length_q;
  logic            cmd_push, cmd_full, cmd_pop, cmd_valid;
  cmd_t            cmd_in, cmd_out;

  // Length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_length_q <= '0;
    end else if (cfg_we_i) begin
      total_length_q <= cfg_wdata_i;
    end
  end

  lzss_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .total_length_i (total_length_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .cmd_full_i     (cmd_full),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  lzss_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out)
  );

  lzss_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .total_length_i (total_length_q),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd_out),
    .cmd_pop_o      (cmd_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .run_last_o     (run_last_o),
    .done_res_o     (done_res_o)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> run_last_o)
    else $error("final byte not marked as end of run");
`endif

endmodule
